>>> sv/wvp_pkg.sv
// ============================================================================
// wvp_pkg
// Types, constants and per-stage datapath logic for the water vapor pressure
// pipeline.
// ============================================================================
package wvp_pkg;

    localparam int QBITS = 30;

    localparam logic [63:0] QHALF = 64'd1 << (QBITS - 1);
    localparam logic [63:0] QONE  = 64'd1 << QBITS;

    localparam logic [63:0] COEF_A_Q = ((64'd776451 << QBITS) + 64'd50000) / 64'd100000;
    localparam logic [63:0] COEF_B_Q = ((64'd145838 << QBITS) + 64'd50000) / 64'd100000;
    localparam logic [63:0] COEF_C_Q = ((64'd27758 << QBITS) + 64'd5000) / 64'd10000;
    localparam logic [63:0] COEF_D_Q = ((64'd123303 << QBITS) + 64'd50000) / 64'd100000;
    localparam logic [63:0] LOG2E_Q  =
        ((64'd14426950409 << QBITS) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] LN2_Q    =
        ((64'd6931471806 << QBITS) + 64'd5000000000) / 64'd10000000000;

    localparam logic [15:0] TC_CENTI_K     = 16'd64730;
    localparam logic [14:0] ZERO_C_CENTI_K = 15'd27315;
    localparam logic [29:0] TAU_LOW        = 30'd32365;
    localparam logic [63:0] TAU_RECIP      = (64'd1 << 46) / 64'd64730;
    localparam logic [63:0] TAU_TWO_TC     = 64'd129460;
    localparam logic [63:0] PC_CENTI_HPA   = 64'd22120000;
    localparam logic [11:0] TEMP_MAX_CENTI = 12'd4000;
    localparam logic [9:0]  HUM_FULL       = 10'd1000;
    localparam logic [12:0] OUT_MAX        = 13'd8191;
    localparam logic [34:0] M_CAP          = 35'd11 << QBITS;
    localparam logic [63:0] HUM_HALF_Q     = 64'd500 << QBITS;
    localparam logic [63:0] RECIP_1000     = 64'd17179869;

    // Pipeline phases and their first stage.
    localparam int PH_TAU = 0;
    localparam int PH_SQ  = 1;
    localparam int PH_POW = 2;
    localparam int PH_SER = 3;
    localparam int PH_MD  = 4;
    localparam int PH_DIV = 5;
    localparam int PH_Y   = 6;
    localparam int PH_TAY = 7;
    localparam int PH_FIN = 8;

    localparam int B_TAU = 0;
    localparam int B_SQ  = 3;
    localparam int B_POW = 18;
    localparam int B_SER = 26;
    localparam int B_MD  = 32;
    localparam int B_DIV = 34;
    localparam int B_Y   = 52;
    localparam int B_TAY = 58;
    localparam int B_FIN = 123;
    localparam int NST   = 131;

    localparam int TAY_STAGES = 5;

    typedef struct packed {
        logic        flag;
        logic [9:0]  hum;
        logic [14:0] tk;
        logic [29:0] tau;
        logic [29:0] rt;
        logic [29:0] t15;
        logic [29:0] t2;
        logic [29:0] t3;
        logic [29:0] t6;
        logic [62:0] acc;
        logic [63:0] pa;
        logic [32:0] rem;
        logic [34:0] quo;
        logic [32:0] n30;
        logic [33:0] m;
        logic [3:0]  nsh;
        logic [29:0] fr;
        logic [29:0] x;
        logic [30:0] term;
        logic [29:0] tm;
        logic [31:0] sum;
        logic [43:0] pqv;
        logic [12:0] sat;
        logic [23:0] vq;
        logic [12:0] vap;
    } wvp_ctx_t;

    function automatic logic [63:0] wvp_round(input logic [63:0] v);
        return (v + QHALF) >> QBITS;
    endfunction

    function automatic logic [63:0] wvp_recip(input int k);
        logic [63:0] r;
        case (k)
            2:       r = 64'd2147483648;
            3:       r = 64'd1431655765;
            4:       r = 64'd1073741824;
            5:       r = 64'd858993459;
            6:       r = 64'd715827882;
            7:       r = 64'd613566756;
            8:       r = 64'd536870912;
            9:       r = 64'd477218588;
            10:      r = 64'd429496729;
            11:      r = 64'd390451572;
            12:      r = 64'd357913941;
            13:      r = 64'd330382099;
            default: r = 64'd4294967296;
        endcase
        return r;
    endfunction

    function automatic wvp_ctx_t wvp_stage(input wvp_ctx_t ci, input int ph, input int sub,
                                           input int k);
        wvp_ctx_t    c;
        logic [63:0] tmp;
        logic [15:0] r16;
        logic [32:0] r33;
        logic [31:0] trial;
        logic [59:0] vb;
        logic [1:0]  pr;
        logic [29:0] q0;
        logic [29:0] diff;
        logic [23:0] d24;
        logic [13:0] v14;
        logic [4:0]  sh;
        int          s;
        c = ci;
        case (ph)
            PH_TAU:
            begin
                case (sub)
                    0:       c.pa = 64'(c.rem[15:0]) * TAU_RECIP;
                    1:
                    begin
                        c.quo = 35'(c.pa[45:16]);
                        c.pa  = 64'(c.pa[45:16]) * 64'(TC_CENTI_K);
                    end
                    default:
                    begin
                        tmp = {18'd0, c.rem[15:0], TAU_LOW} - c.pa;
                        if (tmp >= TAU_TWO_TC)
                        begin
                            c.quo = c.quo + 35'd2;
                        end
                        else if (tmp >= 64'(TC_CENTI_K))
                        begin
                            c.quo = c.quo + 35'd1;
                        end
                    end
                endcase
            end
            PH_SQ:
            begin
                if (sub == 0)
                begin
                    c.tau = c.quo[29:0];
                    c.rem = '0;
                    c.quo = '0;
                end
                vb = {c.tau, 30'd0};
                for (int u = 0; u < 2; u++)
                begin
                    s = 29 - (2 * sub + u);
                    pr = vb[2 * s +: 2];
                    r33 = {c.rem[30:0], pr};
                    trial = {c.quo[29:0], 2'b01};
                    if (r33 >= {1'b0, trial})
                    begin
                        r33 = r33 - {1'b0, trial};
                        c.quo = {c.quo[33:0], 1'b1};
                    end
                    else
                    begin
                        c.quo = {c.quo[33:0], 1'b0};
                    end
                    c.rem = r33;
                end
            end
            PH_POW:
            begin
                case (sub)
                    0:
                    begin
                        c.rt = c.quo[29:0];
                        c.pa = 64'(c.tau) * 64'(c.quo[29:0]);
                    end
                    1:       begin tmp = wvp_round(c.pa); c.t15 = tmp[29:0]; end
                    2:       c.pa = 64'(c.tau) * 64'(c.tau);
                    3:       begin tmp = wvp_round(c.pa); c.t2 = tmp[29:0]; end
                    4:       c.pa = 64'(c.t2) * 64'(c.tau);
                    5:       begin tmp = wvp_round(c.pa); c.t3 = tmp[29:0]; end
                    6:       c.pa = 64'(c.t3) * 64'(c.t3);
                    default: begin tmp = wvp_round(c.pa); c.t6 = tmp[29:0]; end
                endcase
            end
            PH_SER:
            begin
                case (sub)
                    0:       c.pa = COEF_A_Q * 64'(c.tau);
                    1:
                    begin
                        c.acc = c.pa[62:0];
                        c.pa = COEF_C_Q * 64'(c.t3);
                    end
                    2:
                    begin
                        c.acc = c.acc + c.pa[62:0];
                        c.pa = COEF_D_Q * 64'(c.t6);
                    end
                    3:
                    begin
                        c.acc = c.acc + c.pa[62:0];
                        c.pa = COEF_B_Q * 64'(c.t15);
                    end
                    4:       c.acc = (c.acc > c.pa[62:0]) ? c.acc - c.pa[62:0] : '0;
                    default: begin tmp = wvp_round({1'b0, c.acc}); c.n30 = tmp[32:0]; end
                endcase
            end
            PH_MD:
            begin
                if (sub == 0)
                begin
                    c.pa = 64'(c.n30) * 64'(TC_CENTI_K);
                end
                else
                begin
                    c.pa = c.pa + 64'(c.tk[14:1]);
                    c.rem = 33'(c.pa[48:35]);
                    c.quo = '0;
                end
            end
            PH_DIV:
            begin
                for (int u = 0; u < 2; u++)
                begin
                    s = 2 * sub + u;
                    if (s < 35)
                    begin
                        r16 = {c.rem[14:0], c.pa[34 - s]};
                        if (r16 >= {1'b0, c.tk})
                        begin
                            r16 = r16 - {1'b0, c.tk};
                            c.quo = {c.quo[33:0], 1'b1};
                        end
                        else
                        begin
                            c.quo = {c.quo[33:0], 1'b0};
                        end
                        c.rem = 33'(r16);
                    end
                end
            end
            PH_Y:
            begin
                case (sub)
                    0:       c.m = (c.quo > M_CAP) ? M_CAP[33:0] : c.quo[33:0];
                    1:       c.pa = 64'(c.m) * LOG2E_Q;
                    2:
                    begin
                        tmp = wvp_round(c.pa);
                        c.nsh = tmp[33:30];
                        c.fr = tmp[29:0];
                    end
                    3:       c.term = QONE[30:0] - {1'b0, c.fr};
                    4:       c.pa = 64'(c.term) * LN2_Q;
                    default:
                    begin
                        tmp = wvp_round(c.pa);
                        c.x = tmp[29:0];
                        c.term = QONE[30:0];
                        c.sum = '0;
                    end
                endcase
            end
            PH_TAY:
            begin
                case (sub)
                    0:
                    begin
                        c.pa = 64'(c.term) * 64'(c.x);
                        c.sum = c.sum + 32'(c.term);
                    end
                    1:       begin tmp = wvp_round(c.pa); c.tm = tmp[29:0]; end
                    2:       c.pa = 64'(c.tm) * wvp_recip(k);
                    3:
                    begin
                        q0 = c.pa[61:32];
                        c.quo = 35'(q0);
                        c.rem = 33'(34'(q0) * 34'(k));
                    end
                    default:
                    begin
                        diff = c.tm - c.rem[29:0];
                        c.term = {1'b0, c.quo[29:0] + 30'(diff >= 30'(k))};
                    end
                endcase
            end
            default:
            begin
                case (sub)
                    0:       c.sum = c.sum + 32'(c.term);
                    1:       c.pa = PC_CENTI_HPA * 64'(c.sum);
                    2:
                    begin
                        sh = 5'(c.nsh) + 5'd1;
                        tmp = (c.pa + (64'd1 << c.nsh)) >> sh;
                        c.pqv = tmp[43:0];
                    end
                    3:
                    begin
                        tmp = wvp_round(64'(c.pqv));
                        c.sat = (tmp > 64'(OUT_MAX)) ? OUT_MAX : tmp[12:0];
                        c.pa = 64'(c.pqv) * 64'(c.hum);
                    end
                    4:       begin tmp = c.pa + HUM_HALF_Q; c.vq = tmp[53:30]; end
                    5:       c.pa = 64'(c.vq) * RECIP_1000;
                    6:
                    begin
                        c.quo = 35'(c.pa[47:34]);
                        c.rem = 33'(c.pa[47:34]) * 33'(HUM_FULL);
                    end
                    default:
                    begin
                        d24 = c.vq - c.rem[23:0];
                        v14 = c.quo[13:0] + 14'(d24 >= 24'(HUM_FULL));
                        c.vap = (v14 > 14'(OUT_MAX)) ? OUT_MAX : v14[12:0];
                    end
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

>>> sv/water_vapor_pressure_from_humidity.sv
// ============================================================================
// water_vapor_pressure_from_humidity
// Saturation and partial water vapor pressure from temperature and humidity.
// ============================================================================
// Throughput: one word per cycle; the whole pipeline holds while the output stalls.
// The depth comes from the bit-serial divide by temperature, the square root and the
// Taylor series.
// Reset clears all valid bits; data registers are not reset.
module water_vapor_pressure_from_humidity
    import wvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // temp_centi_celsius, humidity_deci_percent
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // vapor_centi_hpa, saturation_centi_hpa, zero fill
    output logic        m_axis_tuser    // out_of_range
);

    logic                  adv;
    logic [NST:0]          vld_reg;
    wvp_ctx_t              ctx_reg [0:NST];
    wvp_ctx_t              ctx_next [0:NST-1];
    wvp_ctx_t              dec;
    logic signed [13:0]    temp_in;
    logic [11:0]           temp_clamped;
    logic [9:0]            hum_in;

    assign adv           = !vld_reg[NST] || m_axis_tready;
    assign s_axis_tready = adv;

    always_comb
    begin
        temp_in = s_axis_tdata[13:0];
        hum_in  = s_axis_tdata[23:14];
        dec     = '0;
        if (temp_in < 14'sd0)
        begin
            temp_clamped = '0;
            dec.flag     = 1'b1;
        end
        else if (temp_in > 14'sd4000)
        begin
            temp_clamped = TEMP_MAX_CENTI;
            dec.flag     = 1'b1;
        end
        else
        begin
            temp_clamped = temp_in[11:0];
        end
        if (hum_in > HUM_FULL)
        begin
            dec.hum  = HUM_FULL;
            dec.flag = 1'b1;
        end
        else
        begin
            dec.hum = hum_in;
        end
        dec.tk  = 15'(temp_clamped) + ZERO_C_CENTI_K;
        dec.rem = 33'(TC_CENTI_K - {1'b0, dec.tk});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-1:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_reg[0] <= dec;
        end
    end

    for (genvar g = 0; g < NST; g++)
    begin : g_stage
        localparam int PH  = (g < B_SQ)  ? PH_TAU :
                             (g < B_POW) ? PH_SQ  :
                             (g < B_SER) ? PH_POW :
                             (g < B_MD)  ? PH_SER :
                             (g < B_DIV) ? PH_MD  :
                             (g < B_Y)   ? PH_DIV :
                             (g < B_TAY) ? PH_Y   :
                             (g < B_FIN) ? PH_TAY : PH_FIN;
        localparam int BASE = (g < B_SQ)  ? B_TAU :
                              (g < B_POW) ? B_SQ  :
                              (g < B_SER) ? B_POW :
                              (g < B_MD)  ? B_SER :
                              (g < B_DIV) ? B_MD  :
                              (g < B_Y)   ? B_DIV :
                              (g < B_TAY) ? B_Y   :
                              (g < B_FIN) ? B_TAY : B_FIN;
        localparam int SUB = (PH == PH_TAY) ? (g - BASE) % TAY_STAGES : g - BASE;
        localparam int K   = (PH == PH_TAY) ? (g - BASE) / TAY_STAGES + 1 : 1;

        always_comb
        begin
            ctx_next[g] = wvp_stage(ctx_reg[g], PH, SUB, K);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ctx_reg[g+1] <= ctx_next[g];
            end
        end
    end

    assign m_axis_tvalid = vld_reg[NST];
    assign m_axis_tdata  = {6'd0, ctx_reg[NST].sat, ctx_reg[NST].vap};
    assign m_axis_tuser  = ctx_reg[NST].flag;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the water vapor pressure pipeline: random and edge
// temperature/humidity words are streamed in under varying back-pressure and
// every output word is compared against a fixed-point Wagner-series predictor.
// ============================================================================
module tb_top;

    typedef struct packed {
        logic [12:0] vap;
        logic [12:0] sat;
        logic        flag;
    } pressure_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    logic [23:0] sample_q[$];
    pressure_t   expected_q[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          errors;
    int          words_in;
    int          words_out;
    int          flagged_out;

    water_vapor_pressure_from_humidity uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic pressure_t predict_pressure(input logic [23:0] word);
        localparam logic [63:0] QONE = 64'd1 << 30;
        localparam logic [63:0] QHALF = 64'd1 << 29;
        logic [63:0] ca, cb, cc, cd, l2e, ln2;
        logic signed [13:0] t;
        logic [63:0] hum, tk, tau, rt, t15, t2, t3, t6, negp, posp, n30, m, y, n, f, x;
        logic [63:0] term, sum, pq, sat, vap;
        pressure_t r;
        ca = ((64'd776451 << 30) + 64'd50000) / 64'd100000;
        cb = ((64'd145838 << 30) + 64'd50000) / 64'd100000;
        cc = ((64'd27758 << 30) + 64'd5000) / 64'd10000;
        cd = ((64'd123303 << 30) + 64'd50000) / 64'd100000;
        l2e = ((64'd14426950409 << 30) + 64'd5000000000) / 64'd10000000000;
        ln2 = ((64'd6931471806 << 30) + 64'd5000000000) / 64'd10000000000;
        t = word[13:0];
        hum = word[23:14];
        r.flag = 1'b0;
        if (t < 0)
        begin
            t = 0;
            r.flag = 1'b1;
        end
        else if (t > 4000)
        begin
            t = 4000;
            r.flag = 1'b1;
        end
        if (hum > 1000)
        begin
            hum = 1000;
            r.flag = 1'b1;
        end
        tk = 64'(t) + 64'd27315;
        tau = (((64'd64730 - tk) << 30) + 64'd32365) / 64'd64730;
        rt = int_sqrt(tau << 30);
        t15 = q_mul(tau, rt);
        t2 = q_mul(tau, tau);
        t3 = q_mul(t2, tau);
        t6 = q_mul(t3, t3);
        negp = ca * tau + cc * t3 + cd * t6;
        posp = cb * t15;
        negp = (negp > posp) ? negp - posp : 64'd0;
        n30 = (negp + QHALF) >> 30;
        m = (n30 * 64'd64730 + tk / 2) / tk;
        if (m > 11 * QONE)
            m = 11 * QONE;
        y = (m * l2e + QHALF) >> 30;
        n = y >> 30;
        f = y & (QONE - 1);
        if (n > 40)
            n = 40;
        x = q_mul(QONE - f, ln2);
        term = QONE;
        sum = QONE;
        for (int k = 1; k < 14; k++)
        begin
            term = q_mul(term, x) / k;
            sum = sum + term;
        end
        pq = (64'd22120000 * sum + (64'd1 << n)) >> (n + 1);
        sat = (pq + QHALF) >> 30;
        vap = (pq * hum + 64'd500 * QONE) / (64'd1000 * QONE);
        r.sat = (sat > 8191) ? 13'd8191 : sat[12:0];
        r.vap = (vap > 8191) ? 13'd8191 : vap[12:0];
        return r;
    endfunction

    function automatic logic [23:0] pack_sample(input int temp, input int hum);
        logic [13:0] t14;
        logic [9:0]  h10;
        t14 = temp[13:0];
        h10 = hum[9:0];
        return {h10, t14};
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                expected_q.push_back(predict_pressure(s_axis_tdata));
                words_in++;
            end
            if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= sample_q.pop_front();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected output word %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    pressure_t e;
                    e = expected_q.pop_front();
                    words_out++;
                    flagged_out += m_axis_tuser;
                    if (m_axis_tdata[12:0] !== e.vap)
                    begin
                        $error("vapor_centi_hpa expected %0d got %0d", e.vap, m_axis_tdata[12:0]);
                        errors++;
                    end
                    if (m_axis_tdata[25:13] !== e.sat)
                    begin
                        $error("saturation_centi_hpa expected %0d got %0d",
                               e.sat, m_axis_tdata[25:13]);
                        errors++;
                    end
                    if (m_axis_tuser !== e.flag)
                    begin
                        $error("out_of_range expected %0d got %0d", e.flag, m_axis_tuser);
                        errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int temps[12];
        int hums[6];
        temps = '{-8192, -2000, -1, 0, 1, 2000, 3999, 4000, 4001, 6000, 8191, 2500};
        hums = '{0, 1, 500, 1000, 1001, 1023};
        errors = 0;
        words_in = 0;
        words_out = 0;
        flagged_out = 0;
        send_idle_pct = 15;
        recv_idle_pct = 62;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 12; i++)
            sample_q.push_back(pack_sample(temps[i], hums[i % 6]));
        for (int i = 0; i < 6; i++)
            sample_q.push_back(pack_sample(2000, hums[i]));
        for (int p = 0; p < 3; p++)
        begin
            for (int i = 0; i < 600; i++)
            begin
                case ($urandom_range(9))
                    0:       sample_q.push_back(24'($urandom()));
                    1:       sample_q.push_back(pack_sample($urandom_range(6000) - 2000,
                                                            $urandom_range(1023)));
                    default: sample_q.push_back(pack_sample($urandom_range(4000),
                                                            $urandom_range(1000)));
                endcase
            end
            while (sample_q.size() > 0 || s_axis_tvalid)
                @(posedge clk);
            if (p == 0)
            begin
                send_idle_pct = 62;
                recv_idle_pct = 15;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end
        while (expected_q.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Checked %0d of %0d words across clamp, saturation and back-pressure cases.",
                 words_out, words_in);
        $display("%0d output words carried the out-of-range flag.", flagged_out);
        if (errors == 0)
            $display("water_vapor_pressure_from_humidity verification clean");
        else
            $display("water_vapor_pressure_from_humidity verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("water_vapor_pressure_from_humidity verification failed");
        $finish;
    end

endmodule

>>> water_vapor_pressure_from_humidity.f
sv/wvp_pkg.sv
sv/water_vapor_pressure_from_humidity.sv
tb/tb_top.sv
